// ----- rtl/fccm_pkg.sv -----
// Package for the FAT cluster chain manager.
// Holds the shared codes, constants and the controller/datapath interface types.
// No dependencies.
package fccm_pkg;

    // Default table depth.
    localparam int unsigned DEF_MAX_CLUSTERS = 1024;

    // Link values.
    localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;
    localparam logic [31:0] END_MIN  = 32'hFFFF_FFF8;

    // Register reset values.
    localparam logic [10:0] CLUS_TOTAL_RESET   = 11'd100;
    localparam logic [10:0] ROOT_CLUSTER_RESET = 11'd2;

    // Register indexes on the configuration port.
    localparam logic REG_CLUS_TOTAL   = 1'b0;
    localparam logic REG_ROOT_CLUSTER = 1'b1;

    // Request types.
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    // Source of the result payload.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_FIRST,
        RES_RDATA,
        RES_END,
        RES_FREED
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;       // latch request fields, clear counters
        logic     clr_wr;     // write one clear entry, advance the sweep index
        logic     scan_rd;    // read the entry at the scan index
        logic     scan_eval;  // act on the scanned entry, advance the scan index
        logic     alloc_end;  // terminate the new chain at its last cluster
        logic     rb_start;   // point the walk at the first allocated cluster
        logic     walk_rd;    // read the entry of the current cluster
        logic     walk_wr;    // zero the current entry, follow its link
        logic     finish;     // present a result
        logic [1:0] status;
        res_sel_t res_sel;
    } fccm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_end;       // scan index reached the cluster count
        logic idx_last;      // sweep index at the last table entry
        logic rd_free;       // read data is a free entry
        logic rd_end;        // read data is an end-of-chain mark
        logic got_last;      // this cluster completes the allocation
        logic cur_in_range;  // current cluster lies inside the table
        logic cur_zero;      // current cluster is zero
        logic freed_lim;     // free walk reached the step bound
    } fccm_stat_t;

endpackage

// ----- rtl/fccm_ctrl.sv -----
// Controller state machine of the FAT cluster chain manager.
// Depends on fccm_pkg; drives the datapath fccm_dp through command beats.
module fccm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             req_type,
    input  fccm_pkg::fccm_stat_t   stat,
    output fccm_pkg::fccm_cmd_t    cmd,
    output logic                   busy
);
    import fccm_pkg::*;

    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_CLEAR       = 4'd1;
    localparam logic [3:0] S_SCAN_RD     = 4'd2;
    localparam logic [3:0] S_SCAN_CHK    = 4'd3;
    localparam logic [3:0] S_ALLOC_END   = 4'd4;
    localparam logic [3:0] S_RB_RD       = 4'd5;
    localparam logic [3:0] S_RB_WR       = 4'd6;
    localparam logic [3:0] S_FREE_RD     = 4'd7;
    localparam logic [3:0] S_FREE_WR     = 4'd8;
    localparam logic [3:0] S_LOOKUP      = 4'd9;
    localparam logic [3:0] S_LOOKUP_WAIT = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ready_reg;
    logic       ready_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        cmd         = '0;
        cmd.status  = ST_OK;
        cmd.res_sel = RES_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (req_type == REQ_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (!ready_reg)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_NOT_READY;
                    end
                    else
                    begin
                        unique case (req_type)
                            REQ_ALLOC:  state_next = S_SCAN_RD;
                            REQ_FREE:   state_next = S_FREE_RD;
                            default:    state_next = S_LOOKUP;
                        endcase
                    end
                end
            end

            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.finish = 1'b1;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SCAN_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.rb_start = 1'b1;
                    state_next   = S_RB_RD;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = (stat.rd_free && stat.got_last) ? S_ALLOC_END : S_SCAN_RD;
            end

            S_ALLOC_END:
            begin
                cmd.alloc_end = 1'b1;
                cmd.finish    = 1'b1;
                cmd.res_sel   = RES_FIRST;
                state_next    = S_IDLE;
            end

            S_RB_RD:
            begin
                if (stat.cur_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_NO_SPACE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_RB_WR;
                end
            end

            S_RB_WR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = S_RB_RD;
            end

            S_FREE_RD:
            begin
                if (stat.cur_in_range && !stat.freed_lim)
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_FREE_WR;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_FREED;
                    state_next  = S_IDLE;
                end
            end

            S_FREE_WR:
            begin
                cmd.walk_wr = 1'b1;
                if (stat.rd_end)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_FREED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_FREE_RD;
                end
            end

            S_LOOKUP:
            begin
                if (stat.cur_in_range)
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_LOOKUP_WAIT;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_END;
                    state_next  = S_IDLE;
                end
            end

            S_LOOKUP_WAIT:
            begin
                cmd.finish  = 1'b1;
                cmd.res_sel = RES_RDATA;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/fccm_dp.sv -----
// Datapath of the FAT cluster chain manager: link table memory, counters and result registers.
// Depends on fccm_pkg; controlled by fccm_ctrl.
module fccm_dp #(
    parameter int unsigned MAX_CLUSTERS = fccm_pkg::DEF_MAX_CLUSTERS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [10:0]            cfg_data,
    input  logic [31:0]            cluster,
    input  logic [10:0]            count,
    input  fccm_pkg::fccm_cmd_t    cmd,
    output fccm_pkg::fccm_stat_t   stat,
    output logic                   done,
    output logic [1:0]             status,
    output logic [31:0]            value,
    output logic [10:0]            freed
);
    import fccm_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CLUSTERS);
    localparam int unsigned NW = $clog2(MAX_CLUSTERS + 1);
    localparam int unsigned CW = (NW > 11) ? NW : 11;
    localparam logic [NW-1:0] LAST_IDX = NW'(MAX_CLUSTERS - 1);
    localparam logic [CW-1:0] MAX_CW   = CW'(MAX_CLUSTERS);

    // Configuration registers.
    logic [10:0] clus_total_reg;
    logic [10:0] root_cluster_reg;

    // Working registers.
    logic [NW-1:0] idx_reg;
    logic [31:0]   cur_reg;
    logic [AW-1:0] prev_reg;
    logic          have_prev_reg;
    logic [10:0]   got_reg;
    logic [10:0]   target_reg;
    logic [CW-1:0] freed_reg;
    logic [CW-1:0] freed_next;

    // The first cluster is kept apart from the running chain tail.
    logic [AW-1:0] first_reg;

    // Result registers.
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [31:0]   value_reg;
    logic [10:0]   freed_out_reg;

    // Link table.
    logic [31:0]   link_mem [MAX_CLUSTERS];
    logic [31:0]   rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;

    logic [CW-1:0] n_eff;
    logic [CW-1:0] cc_ext;
    logic [31:0]   cur_m2;
    logic [AW-1:0] cur_idx;
    logic [10:0]   root_m2;
    logic          root_ok;
    logic [31:0]   idx_cluster;
    logic [31:0]   clear_val;

    assign cc_ext  = CW'(clus_total_reg);
    assign n_eff   = (cc_ext > MAX_CW) ? MAX_CW : cc_ext;
    assign cur_m2  = cur_reg - 32'd2;
    assign cur_idx = cur_m2[AW-1:0];
    assign root_m2 = root_cluster_reg - 11'd2;
    assign root_ok = (root_cluster_reg >= 11'd2) && (CW'(root_m2) < MAX_CW);

    assign idx_cluster = 32'(idx_reg[AW-1:0]) + 32'd2;
    assign clear_val   = (root_ok && (CW'(idx_reg) == CW'(root_m2))) ? END_MARK : 32'd0;
    assign freed_next  = cmd.walk_wr ? (freed_reg + CW'(1)) : freed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clus_total_reg   <= CLUS_TOTAL_RESET;
            root_cluster_reg <= ROOT_CLUSTER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CLUS_TOTAL: clus_total_reg   <= cfg_data;
                default:        root_cluster_reg <= cfg_data;
            endcase
        end
    end

    // Memory port mux; the controller never issues two port users at once.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = idx_reg[AW-1:0];
        mem_wdata = 32'd0;
        if (cmd.clr_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = clear_val;
        end
        else if (cmd.scan_rd)
        begin
            mem_addr  = idx_reg[AW-1:0];
        end
        else if (cmd.scan_eval)
        begin
            mem_we    = stat.rd_free && have_prev_reg;
            mem_addr  = prev_reg;
            mem_wdata = idx_cluster;
        end
        else if (cmd.alloc_end)
        begin
            mem_we    = 1'b1;
            mem_addr  = prev_reg;
            mem_wdata = END_MARK;
        end
        else if (cmd.walk_rd || cmd.walk_wr)
        begin
            mem_we    = cmd.walk_wr;
            mem_addr  = cur_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= link_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg       <= cluster;
            target_reg    <= (count == 11'd0) ? 11'd1 : count;
            idx_reg       <= '0;
            got_reg       <= '0;
            have_prev_reg <= 1'b0;
            freed_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                idx_reg <= idx_reg + NW'(1);
            end
            if (cmd.scan_eval)
            begin
                idx_reg <= idx_reg + NW'(1);
                if (stat.rd_free)
                begin
                    prev_reg      <= idx_reg[AW-1:0];
                    have_prev_reg <= 1'b1;
                    got_reg       <= got_reg + 11'd1;
                    if (!have_prev_reg)
                    begin
                        first_reg <= idx_reg[AW-1:0];
                    end
                end
            end
            if (cmd.rb_start)
            begin
                cur_reg <= have_prev_reg ? (32'(first_reg) + 32'd2) : 32'd0;
            end
            if (cmd.walk_wr)
            begin
                cur_reg   <= rdata_reg;
                freed_reg <= freed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            case (cmd.res_sel)
                RES_FIRST:
                begin
                    value_reg     <= 32'(first_reg) + 32'd2;
                    freed_out_reg <= 11'd0;
                end
                RES_RDATA:
                begin
                    value_reg     <= rdata_reg;
                    freed_out_reg <= 11'd0;
                end
                RES_END:
                begin
                    value_reg     <= END_MARK;
                    freed_out_reg <= 11'd0;
                end
                RES_FREED:
                begin
                    value_reg     <= 32'd0;
                    freed_out_reg <= freed_next[10:0];
                end
                default:
                begin
                    value_reg     <= 32'd0;
                    freed_out_reg <= 11'd0;
                end
            endcase
        end
    end

    assign stat.idx_end      = (CW'(idx_reg) >= n_eff);
    assign stat.idx_last     = (idx_reg == LAST_IDX);
    assign stat.rd_free      = (rdata_reg == 32'd0);
    assign stat.rd_end       = (rdata_reg >= END_MIN);
    assign stat.got_last     = ((got_reg + 11'd1) == target_reg);
    assign stat.cur_in_range = (cur_reg >= 32'd2) && (cur_reg < (32'(n_eff) + 32'd2));
    assign stat.cur_zero     = (cur_reg == 32'd0);
    assign stat.freed_lim    = (freed_reg >= n_eff);

    assign done   = done_reg;
    assign status = status_reg;
    assign value  = value_reg;
    assign freed  = freed_out_reg;

endmodule

// ----- rtl/fat_cluster_chain_manager.sv -----
// Top level of the FAT cluster chain manager.
// Depends on fccm_pkg, fccm_ctrl and fccm_dp.
//
//  Channel   Handshake            Payload                     Direction
//  -------   ---------            -------                     ---------
//  request   start / busy         req_type, cluster, count    in
//  result    done (strobe)        status, value, freed        out
//  config    cfg_we               cfg_addr, cfg_data          in
//
// A request beat is taken at a clock edge where start is high and busy is low, and
// one request is served at a time through a single-port table with a registered read.
// Clear sweeps the whole table; allocate reads and then checks each entry scanned, free
// reads and then zeroes each link, and lookup reads the entry of an in-range cluster. The
// slowest request is an allocation that runs out of space: a full scan and then a read
// and a write for each cluster rolled back.
// After reset every request but clear answers not ready until a clear is done.
// The result beat on done lasts one cycle and cannot be stalled; the next request may
// be given in that same cycle.
module fat_cluster_chain_manager #(
    parameter int unsigned MAX_CLUSTERS = fccm_pkg::DEF_MAX_CLUSTERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] cluster,
    input  logic [10:0] count,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] value,
    output logic [10:0] freed
);
    import fccm_pkg::*;

    fccm_cmd_t  cmd;
    fccm_stat_t stat;

    // Sequencing of table accesses for each request type.
    fccm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Table memory, configuration registers and result registers.
    fccm_dp #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cluster  (cluster),
        .count    (count),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .status   (status),
        .value    (value),
        .freed    (freed)
    );

    // A result beat only follows an accepted request or work in progress.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a request");

    // A rolled back allocation reports no chain.
    a_no_space_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NO_SPACE) |-> (value == 32'd0))
        else $error("no_space result carries a chain");

    // Only a successful request can report freed links.
    a_freed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (freed == 11'd0))
        else $error("freed count on a failed request");

    // The block only becomes busy on an accepted request.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");

endmodule

// ----- bench/fat_chain_checker.sv -----
// Checker for the FAT cluster chain manager: keeps its own copy of the link table,
// predicts one result beat per accepted request and compares the result beats.
// Depends on fccm_pkg for the request, status and register codes.
module fat_chain_checker #(
    parameter int unsigned MAX_CLUSTERS = fccm_pkg::DEF_MAX_CLUSTERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] cluster,
    input  logic [10:0] count,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [31:0] value,
    input  logic [10:0] freed,
    output int          pending,
    output int          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import fccm_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [10:0] freed;
    } chain_result_t;

    logic [31:0]   link_tab [MAX_CLUSTERS];
    bit            table_ready;
    logic [10:0]   reg_count;
    logic [10:0]   reg_root;
    chain_result_t expected_q [$];

    // Clusters in use, saturated to the table depth.
    function automatic int unsigned active_clusters();
        return (reg_count > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(reg_count);
    endfunction

    function automatic bit cluster_valid(logic [31:0] c);
        longint unsigned cc;
        cc = 64'(c);
        return (cc >= 2) && (cc < longint'(active_clusters()) + 2);
    endfunction

    function automatic int unsigned lowest_free_cluster();
        for (int unsigned i = 0; i < active_clusters(); i++)
            if (link_tab[i] == '0)
                return i + 2;
        return 0;
    endfunction

    // Applies one request to the table copy and returns the beat it should produce.
    function automatic chain_result_t serve_request(logic [1:0] req, logic [31:0] cl,
                                                    logic [10:0] cnt);
        chain_result_t r;
        int unsigned   n;
        int unsigned   want;
        int unsigned   head_c;
        int unsigned   prev;
        int unsigned   c;
        int unsigned   cur;
        int unsigned   root_i;
        logic [31:0]   nxt;
        logic [31:0]   walk;
        r = '{status: ST_OK, value: '0, freed: '0};
        n = active_clusters();
        if (req == REQ_CLEAR)
        begin
            foreach (link_tab[i])
                link_tab[i] = '0;
            root_i = 32'(reg_root);
            if (root_i >= 2 && root_i - 2 < MAX_CLUSTERS)
                link_tab[root_i - 2] = END_MARK;
            table_ready = 1'b1;
        end
        else if (!table_ready)
        begin
            r.status = ST_NOT_READY;
        end
        else if (req == REQ_ALLOC)
        begin
            want = (cnt == 0) ? 1 : int'(cnt);
            head_c = 0;
            prev = 0;
            for (int unsigned k = 0; k < want; k++)
            begin
                c = lowest_free_cluster();
                if (c == 0)
                begin
                    // Out of space: undo the partial chain.
                    cur = head_c;
                    while (cur != 0)
                    begin
                        nxt = link_tab[cur - 2];
                        link_tab[cur - 2] = '0;
                        cur = (nxt >= END_MIN) ? 0 : int'(nxt);
                    end
                    r.status = ST_NO_SPACE;
                    head_c = 0;
                    break;
                end
                link_tab[c - 2] = END_MARK;
                if (head_c == 0)
                    head_c = c;
                else
                    link_tab[prev - 2] = c;
                prev = c;
            end
            r.value = head_c;
        end
        else if (req == REQ_FREE)
        begin
            walk = cl;
            while (cluster_valid(walk) && r.freed < n)
            begin
                nxt = link_tab[walk - 2];
                link_tab[walk - 2] = '0;
                r.freed = r.freed + 1'b1;
                if (nxt >= END_MIN)
                    break;
                walk = nxt;
            end
        end
        else
        begin
            r.value = cluster_valid(cl) ? link_tab[cl - 2] : END_MARK;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        chain_result_t want_r;
        if (!rst_n)
        begin
            reg_count = CLUS_TOTAL_RESET;
            reg_root = ROOT_CLUSTER_RESET;
            table_ready = 1'b0;
            expected_q.delete();
        end
        else
        begin
            // A result beat always belongs to a request accepted at an earlier edge,
            // so it is checked before this edge's request is predicted.
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want_r = expected_q.pop_front();
                    if (status !== want_r.status)
                    begin
                        $error("field status expected %0d got %0d", want_r.status, status);
                        mismatches++;
                    end
                    if (value !== want_r.value)
                    begin
                        $error("field value expected 0x%08h got 0x%08h", want_r.value, value);
                        mismatches++;
                    end
                    if (freed !== want_r.freed)
                    begin
                        $error("field freed expected %0d got %0d", want_r.freed, freed);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CLUS_TOTAL:   reg_count = cfg_data;
                    REG_ROOT_CLUSTER: reg_root = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_q.push_back(serve_request(req_type, cluster, count));
        end
        pending = expected_q.size();
    end

endmodule

// ----- bench/fat_cluster_chain_manager_test.sv -----
// Top of the FAT cluster chain manager testbench: clock, reset, request and
// register stimulus, a stall watchdog and the verdict.
// Depends on fccm_pkg, fat_cluster_chain_manager and fat_chain_checker.
module fat_cluster_chain_manager_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fccm_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. The slowest
    // correct request is an allocation that scans a full 1024-entry table and then
    // rolls back, and this limit leaves ample headroom for it.
    localparam int unsigned STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [10:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [31:0] cluster;
    logic [10:0] count;
    logic        done;
    logic [1:0]  status;
    logic [31:0] value;
    logic [10:0] freed;

    int          pending;
    int          mismatches;
    int unsigned quiet_cycles = 0;

    // When set, the sender never idles between requests.
    bit          calm;

    // Heads of chains the block reported as allocated; freeing them gives
    // well-formed free requests. The order queue pairs result beats with requests.
    logic [31:0] live_heads [$];
    bit          alloc_order [$];

    fat_cluster_chain_manager dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .cluster  (cluster),
        .count    (count),
        .done     (done),
        .status   (status),
        .value    (value),
        .freed    (freed)
    );

    fat_chain_checker chain_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .cluster    (cluster),
        .count      (count),
        .done       (done),
        .status     (status),
        .value      (value),
        .freed      (freed),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Collect the first cluster of every successful allocation as it comes back.
    always @(posedge clk)
    begin
        if (done && alloc_order.size() != 0)
        begin
            if (alloc_order.pop_front() && status == ST_OK)
                live_heads.push_back(value);
        end
        if (rst_n && start && !busy)
            alloc_order.push_back(req_type == REQ_ALLOC);
    end

    // The watchdog restarts on every accepted request or result beat.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Presents one request beat and returns at the edge that takes it. Every path
    // begins with a falling-edge assignment, so start is either held for the next
    // request or lowered once, never both in one step.
    task automatic send_request(logic [1:0] kind, logic [31:0] clus, logic [10:0] num);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 9) < 3)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req_type <= kind;
        cluster <= clus;
        count <= num;
        do @(posedge clk); while (busy);
    endtask

    // Stops sending and waits until every outstanding result beat has come back.
    // Each request gives exactly one beat, so the block is idle once none is left.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic addr, logic [10:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random request for a table of n clusters in use. Most traffic is
    // allocations of a few clusters, frees of chains handed out earlier and
    // lookups near the valid range; the rest is wide random noise.
    task automatic random_item(int unsigned n);
        int unsigned pick;
        int unsigned slot;
        logic [31:0] clus;
        logic [10:0] num;
        pick = $urandom_range(0, 99);
        clus = $urandom;
        num = 11'($urandom_range(0, 4));
        if (pick < 2)
        begin
            send_request(REQ_CLEAR, clus, num);
        end
        else if (pick < 40)
        begin
            case ($urandom_range(0, 19))
                0: num = 11'd1024;
                1: num = 11'($urandom_range(0, 1023));
                2, 3: num = 11'($urandom_range(0, (n + 2 > 1024) ? 1024 : n + 2));
                default: ;
            endcase
            send_request(REQ_ALLOC, clus, num);
        end
        else if (pick < 65)
        begin
            if (live_heads.size() != 0 && $urandom_range(0, 9) < 6)
            begin
                slot = $urandom_range(0, live_heads.size() - 1);
                clus = live_heads[slot];
                live_heads.delete(slot);
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                // Often lands in the middle of a chain or on a free link.
                clus = $urandom_range(0, n + 3);
            end
            send_request(REQ_FREE, clus, num);
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
                clus = $urandom_range(0, n + 3);
            send_request(REQ_LOOKUP, clus, num);
        end
    endtask

    // Reprograms both registers while idle, optionally clears the table, then
    // runs a batch of random requests under that setting.
    task automatic run_phase(logic [10:0] cnt, logic [10:0] root, bit wipe,
                             int unsigned items);
        int unsigned n;
        drain();
        write_reg(REG_CLUS_TOTAL, cnt);
        write_reg(REG_ROOT_CLUSTER, root);
        n = (cnt > DEF_MAX_CLUSTERS) ? DEF_MAX_CLUSTERS : int'(cnt);
        if (wipe)
            send_request(REQ_CLEAR, $urandom, 11'($urandom_range(0, 1024)));
        repeat (items) random_item(n);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        req_type = REQ_ALLOC;
        cluster = '0;
        count = '0;
        calm = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Before any clear every request other than clear answers not ready.
        send_request(REQ_ALLOC, 32'd0, 11'd3);
        send_request(REQ_FREE, 32'd2, 11'd0);
        send_request(REQ_LOOKUP, 32'd2, 11'd0);

        // Small table of eight clusters, root at the lowest cluster.
        drain();
        write_reg(REG_CLUS_TOTAL, 11'd8);
        write_reg(REG_ROOT_CLUSTER, 11'd2);
        send_request(REQ_CLEAR, 32'd0, 11'd0);
        send_request(REQ_LOOKUP, 32'd2, 11'd0);
        // Lookups below, at the top of and past the valid range.
        send_request(REQ_LOOKUP, 32'd0, 11'd0);
        send_request(REQ_LOOKUP, 32'd1, 11'd0);
        send_request(REQ_LOOKUP, 32'd9, 11'd0);
        send_request(REQ_LOOKUP, 32'd10, 11'd0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 11'd0);
        // A zero count takes one cluster; the oversized request runs out and
        // must leave the table as it was.
        send_request(REQ_ALLOC, 32'd0, 11'd0);
        send_request(REQ_ALLOC, 32'd0, 11'd3);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 11'd1024);
        send_request(REQ_LOOKUP, 32'd7, 11'd0);
        // Free a whole chain, out-of-range starts, and a start on a free link.
        send_request(REQ_FREE, 32'd4, 11'd0);
        send_request(REQ_FREE, 32'd0, 11'd0);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 11'd0);
        send_request(REQ_FREE, 32'd7, 11'd0);
        // Fill the table exactly, then ask for one more.
        send_request(REQ_ALLOC, 32'd0, 11'd6);
        send_request(REQ_ALLOC, 32'd0, 11'd1);
        send_request(REQ_FREE, 32'd3, 11'd0);

        // No cluster in range at all.
        drain();
        write_reg(REG_CLUS_TOTAL, 11'd0);
        send_request(REQ_ALLOC, 32'd0, 11'd2);
        send_request(REQ_LOOKUP, 32'd2, 11'd0);
        send_request(REQ_FREE, 32'd4, 11'd0);

        // Count saturated to the table depth, root outside the table so clear
        // marks nothing. The whole table becomes one chain and is freed again.
        drain();
        write_reg(REG_CLUS_TOTAL, 11'd2047);
        write_reg(REG_ROOT_CLUSTER, 11'd1026);
        calm = 1'b1;
        send_request(REQ_CLEAR, 32'd0, 11'd0);
        send_request(REQ_LOOKUP, 32'd1025, 11'd0);
        send_request(REQ_LOOKUP, 32'd1026, 11'd0);
        send_request(REQ_ALLOC, 32'd0, 11'd1024);
        send_request(REQ_ALLOC, 32'd0, 11'd0);
        send_request(REQ_FREE, 32'd2, 11'd0);
        send_request(REQ_LOOKUP, 32'd1025, 11'd0);
        calm = 1'b0;

        // Random phases. Some keep the old table while the count changes, so
        // links can point past the range in use. The last phase runs back to back.
        run_phase(11'd16, 11'd2, 1'b1, 62);
        run_phase(11'd1, 11'd2, 1'b1, 60);
        run_phase(11'd6, 11'd900, 1'b1, 60);
        run_phase(11'd30, 11'd0, 1'b1, 62);
        run_phase(11'd24, 11'd1, 1'b0, 60);
        run_phase(11'd1024, 11'd1025, 1'b1, 62);
        run_phase(11'd0, 11'd2047, 1'b0, 50);
        run_phase(11'd12, 11'd13, 1'b1, 62);
        calm = 1'b1;
        run_phase(11'd8, 11'd2, 1'b1, 60);

        drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
